// ===== rtl/ffbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared types and constants for the first-fit bin packer.
// ----------------------------------------------------------------------------
package ffbp_pkg;

  localparam int DEFAULT_MAX_BINS = 64;

  localparam int SIZE_W        = 8;  // item size, capacity and fill, tenths
  localparam int BIN_INDEX_W   = 6;
  localparam int BINS_IN_USE_W = 7;

  // Control bits that ride with each item down the chain
  typedef struct packed {
    logic valid;
    logic placed;
    logic opened;
  } ctl_t;

endpackage

// ===== rtl/ffbp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffbp_cell
// One bin of the chain: holds its capacity and fill, places a passing item
// that fits, opens for the first unplaced item it meets whose size fits in_cap.
// ----------------------------------------------------------------------------
module ffbp_cell #(
  parameter int MAX_BINS = ffbp_pkg::DEFAULT_MAX_BINS,
  parameter int INDEX    = 0,
  localparam int IDX_W   = $clog2(MAX_BINS),
  localparam int CNT_W   = $clog2(MAX_BINS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  ffbp_pkg::ctl_t              in_ctl,
  input  logic [ffbp_pkg::SIZE_W-1:0] in_size,
  input  logic [ffbp_pkg::SIZE_W-1:0] in_cap,
  input  logic [IDX_W-1:0]            in_idx,
  input  logic [ffbp_pkg::SIZE_W-1:0] in_fill,
  input  logic [CNT_W-1:0]            in_cnt,
  output ffbp_pkg::ctl_t              out_ctl,
  output logic [ffbp_pkg::SIZE_W-1:0] out_size,
  output logic [ffbp_pkg::SIZE_W-1:0] out_cap,
  output logic [IDX_W-1:0]            out_idx,
  output logic [ffbp_pkg::SIZE_W-1:0] out_fill,
  output logic [CNT_W-1:0]            out_cnt
);

  logic                        bin_open;
  logic [ffbp_pkg::SIZE_W-1:0] cap;
  logic [ffbp_pkg::SIZE_W-1:0] fill;

  logic [ffbp_pkg::SIZE_W:0]   sum;
  logic                        fits;
  logic                        opens;
  logic                        take;

  assign sum   = {1'b0, fill} + {1'b0, in_size};
  assign fits  = in_ctl.valid && bin_open && !in_ctl.placed && (sum <= {1'b0, cap});
  // Bins open in order, so the first closed cell an unplaced item meets is
  // the next bin to open.
  assign opens = in_ctl.valid && !bin_open && !in_ctl.placed && (in_size <= in_cap);
  assign take  = fits || opens;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_open      <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else if (adv) begin
      out_ctl.valid  <= in_ctl.valid;
      out_ctl.placed <= in_ctl.placed || take;
      out_ctl.opened <= in_ctl.opened || opens;
      if (opens) begin
        bin_open <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (opens) begin
        cap  <= in_cap;
        fill <= in_size;
      end else if (fits) begin
        fill <= sum[ffbp_pkg::SIZE_W-1:0];
      end
      out_size       <= in_size;
      out_cap        <= in_cap;
      out_idx        <= take ? IDX_W'(INDEX) : in_idx;
      out_fill       <= opens ? in_size : (fits ? sum[ffbp_pkg::SIZE_W-1:0] : in_fill);
      out_cnt        <= in_cnt + CNT_W'(bin_open || opens);
    end
  end

endmodule

// ===== rtl/first_fit_bin_packer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bin_packer_top
// Online first-fit bin packer built as a chain of bin cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries item_size and new_bin_capacity.
//   Output channel (out_valid/out_ready) returns one result per item:
//   bin_index, opened_new, rejected, fill_after, bins_in_use.
//   Each item walks the chain of MAX_BINS cells, one cell per cycle unless the
//   chain is frozen; cell i holds bin i. Items stay in order, so every item
//   sees each bin exactly as first-fit leaves it after all earlier items.
//   Throughput: one item per cycle while the receiver does not stall. The
//   first cell loads at the input transfer edge, then the remaining cells
//   and the output register follow in order, each loading the item in turn.
//   When the receiver stalls with a result waiting, the whole chain freezes
//   and in_ready drops; it resumes on the output transfer.
//   Reset closes all bins and empties the chain, with no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_bin_packer_top #(
  parameter int MAX_BINS = ffbp_pkg::DEFAULT_MAX_BINS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ffbp_pkg::SIZE_W-1:0]        item_size,
  input  logic [ffbp_pkg::SIZE_W-1:0]        new_bin_capacity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ffbp_pkg::BIN_INDEX_W-1:0]   bin_index,
  output logic                               opened_new,
  output logic                               rejected,
  output logic [ffbp_pkg::SIZE_W-1:0]        fill_after,
  output logic [ffbp_pkg::BINS_IN_USE_W-1:0] bins_in_use
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  ffbp_pkg::ctl_t              ctl  [0:MAX_BINS];
  logic [ffbp_pkg::SIZE_W-1:0] size [0:MAX_BINS];
  logic [ffbp_pkg::SIZE_W-1:0] cap  [0:MAX_BINS];
  logic [IDX_W-1:0]            idx  [0:MAX_BINS];
  logic [ffbp_pkg::SIZE_W-1:0] fill [0:MAX_BINS];
  logic [CNT_W-1:0]            cnt  [0:MAX_BINS];

  logic        adv;
  logic [31:0] idx_ext;
  logic [31:0] cnt_ext;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign ctl[0]  = '{valid: in_valid, placed: 1'b0, opened: 1'b0};
  assign size[0] = item_size;
  assign cap[0]  = new_bin_capacity;
  assign idx[0]  = '0;
  assign fill[0] = '0;
  assign cnt[0]  = '0;

  for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
    ffbp_cell #(
      .MAX_BINS (MAX_BINS),
      .INDEX    (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctl   (ctl[i]),
      .in_size  (size[i]),
      .in_cap   (cap[i]),
      .in_idx   (idx[i]),
      .in_fill  (fill[i]),
      .in_cnt   (cnt[i]),
      .out_ctl  (ctl[i+1]),
      .out_size (size[i+1]),
      .out_cap  (cap[i+1]),
      .out_idx  (idx[i+1]),
      .out_fill (fill[i+1]),
      .out_cnt  (cnt[i+1])
    );
  end

  assign idx_ext = 32'(idx[MAX_BINS]);
  assign cnt_ext = 32'(cnt[MAX_BINS]);

  // An item that leaves the chain unplaced found no fit and could not open
  // a bin; its index and fill are still zero from the chain entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl[MAX_BINS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bin_index   <= idx_ext[ffbp_pkg::BIN_INDEX_W-1:0];
      opened_new  <= ctl[MAX_BINS].opened;
      rejected    <= !ctl[MAX_BINS].placed;
      fill_after  <= fill[MAX_BINS];
      bins_in_use <= cnt_ext[ffbp_pkg::BINS_IN_USE_W-1:0];
    end
  end

  logic [ffbp_pkg::BINS_IN_USE_W-1:0] cnt_less_one;
  assign cnt_less_one = bins_in_use - ffbp_pkg::BINS_IN_USE_W'(1);

  a_open_not_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && opened_new |-> !rejected)
    else $error("opened bin reported as rejected");

  a_open_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && opened_new |-> cnt_less_one[ffbp_pkg::BIN_INDEX_W-1:0] == bin_index)
    else $error("newly opened bin is not the last open bin");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> fill_after == '0 && bin_index == '0)
    else $error("rejected item carries a placement");

  a_open_fill: assert property (@(posedge clk) disable iff (rst)
    ctl[MAX_BINS].valid && ctl[MAX_BINS].opened |-> ctl[MAX_BINS].placed &&
      fill[MAX_BINS] == size[MAX_BINS])
    else $error("opened bin fill differs from item size");

endmodule

// ===== sim/first_fit_bin_packer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bin_packer_top_tb
// Self-checking bench for the first-fit bin packer. A queue of items (a short
// directed list, then random traffic shaped to fill the bin table and keep
// probing it once full) feeds a clocked driver. Each accepted item runs
// through a local first-fit predictor that keeps its own copy of the bin
// table. A clocked monitor checks each result against the oldest prediction.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module first_fit_bin_packer_top_tb;

  localparam int MAX_BINS = ffbp_pkg::DEFAULT_MAX_BINS;
  localparam int SIZE_W = ffbp_pkg::SIZE_W;
  localparam int BIN_INDEX_W = ffbp_pkg::BIN_INDEX_W;
  localparam int BINS_IN_USE_W = ffbp_pkg::BINS_IN_USE_W;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct {
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] cap;
  } parcel_t;

  typedef struct packed {
    logic [BIN_INDEX_W-1:0]   bin_index;
    logic                     opened_new;
    logic                     rejected;
    logic [SIZE_W-1:0]        fill_after;
    logic [BINS_IN_USE_W-1:0] bins_in_use;
  } placement_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SIZE_W-1:0]        item_size = '0;
  logic [SIZE_W-1:0]        new_bin_capacity = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [BIN_INDEX_W-1:0]   bin_index;
  logic                     opened_new;
  logic                     rejected;
  logic [SIZE_W-1:0]        fill_after;
  logic [BINS_IN_USE_W-1:0] bins_in_use;

  parcel_t    parcels_waiting[$];
  placement_t placements_due[$];

  // predictor copy of the bin table
  int unsigned bin_cap_copy[MAX_BINS];
  int unsigned bin_fill_copy[MAX_BINS];
  int unsigned open_bins = 0;

  int parcels_total = 0;
  int parcels_sent = 0;
  int faults = 0;

  first_fit_bin_packer_top #(
    .MAX_BINS(MAX_BINS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .item_size(item_size),
    .new_bin_capacity(new_bin_capacity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .bin_index(bin_index),
    .opened_new(opened_new),
    .rejected(rejected),
    .fill_after(fill_after),
    .bins_in_use(bins_in_use)
  );

  always #6 clk = ~clk;

  // first-fit search over the open bins, opening a new one if none fits
  task automatic first_fit_place(input logic [SIZE_W-1:0] size,
                                 input logic [SIZE_W-1:0] cap);
    placement_t p;
    bit         found;
    p = '0;
    found = 1'b0;
    for (int b = 0; b < open_bins && !found; b++) begin
      if (bin_fill_copy[b] + size <= bin_cap_copy[b]) begin
        bin_fill_copy[b] = bin_fill_copy[b] + size;
        p.bin_index = b[BIN_INDEX_W-1:0];
        p.fill_after = bin_fill_copy[b][SIZE_W-1:0];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (open_bins < MAX_BINS && size <= cap) begin
        bin_cap_copy[open_bins] = cap;
        bin_fill_copy[open_bins] = size;
        p.bin_index = open_bins[BIN_INDEX_W-1:0];
        p.fill_after = size;
        p.opened_new = 1'b1;
        open_bins++;
      end else begin
        p.rejected = 1'b1;
      end
    end
    p.bins_in_use = open_bins[BINS_IN_USE_W-1:0];
    placements_due = {placements_due, p};
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(15, 60);
  endfunction

  function automatic parcel_t random_parcel();
    parcel_t q;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      q.size = SIZE_W'($urandom_range(0, 40));
      q.cap = SIZE_W'($urandom_range(q.size, 255));
    end else if (r < 80) begin
      q.size = SIZE_W'($urandom_range(41, 255));
      q.cap = SIZE_W'($urandom_range(q.size, 255));
    end else if (r < 92) begin
      // noise: capacity may come out below the size
      q.size = SIZE_W'($urandom_range(0, 255));
      q.cap = SIZE_W'($urandom_range(0, 255));
    end else begin
      q.size = SIZE_W'($urandom_range(0, 255));
      q.cap = $urandom_range(0, 1) ? q.size : 8'd255;
    end
    return q;
  endfunction

  task automatic add_parcel(input int size, input int cap);
    parcel_t q;
    q.size = SIZE_W'(size);
    q.cap = SIZE_W'(cap);
    parcels_waiting = {parcels_waiting, q};
  endtask

  // driver
  int send_gap = 0;
  int send_calm = 0;
  always @(posedge clk) begin
    parcel_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        first_fit_place(item_size, new_bin_capacity);
        parcels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (parcels_waiting.size() > 0) begin
          q = parcels_waiting.pop_front();
          in_valid <= 1'b1;
          item_size <= q.size;
          new_bin_capacity <= q.cap;
          if (send_calm > 0) begin
            send_calm--;
          end else begin
            send_gap = $urandom_range(0, 1) ? 0 : pick_gap();
            if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left = 0;
  int recv_calm = 0;
  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{bin_index, opened_new, rejected, fill_after, bins_in_use};
        if (placements_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("ERROR: unexpected result bin=%0d open=%0b rej=%0b fill=%0d used=%0d",
                     got.bin_index, got.opened_new, got.rejected, got.fill_after,
                     got.bins_in_use);
        end else begin
          want = placements_due.pop_front();
          if (got !== want) begin
            faults++;
            if (faults <= REPORT_LIMIT) begin
              $display("ERROR: result mismatch: expected bin=%0d open=%0b rej=%0b fill=%0d used=%0d",
                       want.bin_index, want.opened_new, want.rejected, want.fill_after,
                       want.bins_in_use);
              $display("       got bin=%0d open=%0b rej=%0b fill=%0d used=%0d",
                       got.bin_index, got.opened_new, got.rejected, got.fill_after,
                       got.bins_in_use);
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = pick_gap();
        end else if ($urandom_range(0, 199) == 0) begin
          recv_calm = $urandom_range(30, 120);
        end
      end
    end
  end

  initial begin
    // directed: zero sizes and capacities, exact fits, too-small capacity
    add_parcel(0, 0);       // zero-capacity bin for a zero-size item
    add_parcel(1, 0);       // no fit, capacity too small
    add_parcel(0, 255);     // zero size lands in the zero-capacity bin
    add_parcel(255, 255);   // full bin in one item
    add_parcel(255, 254);   // capacity one short
    add_parcel(200, 200);
    add_parcel(1, 1);
    add_parcel(128, 255);
    add_parcel(127, 100);   // tops off bin 4 exactly
    add_parcel(85, 170);
    add_parcel(170, 85);    // rejected
    add_parcel(1, 255);     // first fit skips full bins
    add_parcel(0, 0);
    add_parcel(254, 255);
    add_parcel(2, 2);
    add_parcel(255, 0);     // rejected
    for (int k = 0; k < RANDOM_ITEMS; k++)
      parcels_waiting = {parcels_waiting, random_parcel()};
    // late large items once the table is full
    for (int k = 0; k < 6; k++)
      add_parcel(255, 255);
    parcels_total = parcels_waiting.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (parcels_sent < parcels_total || placements_due.size() != 0)
      @(negedge clk);
    repeat (MAX_BINS + 8) @(posedge clk);

    if (faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("ERROR: timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ffbp_pkg.sv
rtl/ffbp_cell.sv
rtl/first_fit_bin_packer_top.sv
sim/first_fit_bin_packer_top_tb.sv
